@@ hdl/lclp_pkg.sv @@
// Shared types, character constants and microcode program of the LED command line parser.
package lclp_pkg;

  // Default line store depth
  localparam int unsigned LINE_LEN = 32;

  // Character codes
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_Z  = 8'h5A;
  localparam logic [7:0] CASE_OFS = 8'h20;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_FOUR  = 8'h34;

  // Token words, first character in element 0
  typedef logic [3:0][7:0] tok_t;
  localparam tok_t WORD_ON  = 32'h0000_6E6F;  // "on"
  localparam tok_t WORD_OFF = 32'h0066_666F;  // "off"
  localparam logic [2:0][7:0] LED_PREFIX = 24'h64_656C;  // "led"

  // Reply codes
  localparam logic [1:0] RPL_ON   = 2'd0;
  localparam logic [1:0] RPL_OFF  = 2'd1;
  localparam logic [1:0] RPL_ERR  = 2'd2;
  localparam logic [1:0] RPL_HELP = 2'd3;

  // Datapath operation selected by a control word
  typedef enum logic [1:0] {
    OP_RECV,
    OP_INIT,
    OP_SCAN,
    OP_EVAL
  } uop_e;

  // Jump condition of a control word
  typedef enum logic [1:0] {
    COND_ALWAYS,
    COND_CR,
    COND_END,
    COND_OUT_FREE
  } cond_e;

  localparam int unsigned PC_W = 2;

  typedef struct packed {
    uop_e            op;
    cond_e           cond;
    logic [PC_W-1:0] target;
    logic            hold;    // stay on this step while the condition is false
  } ucode_t;

  // Status from datapath to sequencer
  typedef struct packed {
    logic cr_seen;   // CR request taken this cycle
    logic scan_end;  // end of stored line reached
    logic out_free;  // result register can take a new result
  } dp_status_t;

  // Control from sequencer to datapath
  typedef struct packed {
    uop_e op;
    logic hit;       // jump condition true this cycle
  } seq_ctrl_t;

  localparam logic [PC_W-1:0] PC_RECV = 2'd0;
  localparam logic [PC_W-1:0] PC_INIT = 2'd1;
  localparam logic [PC_W-1:0] PC_SCAN = 2'd2;
  localparam logic [PC_W-1:0] PC_EVAL = 2'd3;

  // Control store
  function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
    ucode_t w;
    unique case (pc)
      PC_RECV: w = '{op: OP_RECV, cond: COND_CR,       target: PC_INIT, hold: 1'b1};
      PC_INIT: w = '{op: OP_INIT, cond: COND_ALWAYS,   target: PC_SCAN, hold: 1'b0};
      PC_SCAN: w = '{op: OP_SCAN, cond: COND_END,      target: PC_EVAL, hold: 1'b1};
      PC_EVAL: w = '{op: OP_EVAL, cond: COND_OUT_FREE, target: PC_RECV, hold: 1'b1};
      default: w = '{op: OP_RECV, cond: COND_CR,       target: PC_INIT, hold: 1'b1};
    endcase
    return w;
  endfunction

endpackage

@@ hdl/led_command_line_parser.sv @@
// Top level of the LED command line parser: sequencer, datapath and line store.
//
//   Channel   Direction  Handshake                 Payload
//   input     in         in_valid_i / in_ready_o   rx_byte_i
//   result    out        out_valid_o / out_ready_i reply_code_o, lamp_number_o, lamp_states_o
//
// A byte other than CR is taken in the receive step. A CR runs accept, scan start,
// a scan of the stored characters up to the line end or a zero byte, and the decode
// step; the scan loop reads one character per cycle from the line store read port.
// Reset clears the fill count and lamps; the store itself is not cleared. in_ready_o
// is low during a scan, and the decode step waits while an earlier result has not
// been taken.
module led_command_line_parser #(
  parameter int unsigned LineLen = lclp_pkg::LINE_LEN
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] rx_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [1:0] reply_code_o,
  output logic [2:0] lamp_number_o,
  output logic [3:0] lamp_states_o
);
  import lclp_pkg::*;

  localparam int unsigned AddrW = $clog2(LineLen);

  dp_status_t       status;
  seq_ctrl_t        ctrl;
  logic             mem_we;
  logic [AddrW-1:0] mem_waddr, mem_raddr;
  logic [7:0]       mem_wdata, mem_rdata;

  lclp_seq u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .ctrl_o   (ctrl)
  );

  lclp_dp #(
    .LineLen (LineLen)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctrl_i        (ctrl),
    .status_o      (status),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .rx_byte_i     (rx_byte_i),
    .mem_we_o      (mem_we),
    .mem_waddr_o   (mem_waddr),
    .mem_wdata_o   (mem_wdata),
    .mem_raddr_o   (mem_raddr),
    .mem_rdata_i   (mem_rdata),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .reply_code_o  (reply_code_o),
    .lamp_number_o (lamp_number_o),
    .lamp_states_o (lamp_states_o)
  );

  lclp_ram #(
    .Width (8),
    .Depth (LineLen)
  ) u_line_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

endmodule

@@ hdl/lclp_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module lclp_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ hdl/lclp_seq.sv @@
// Microcode sequencer: step counter, control store and conditional jumps.
module lclp_seq (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  lclp_pkg::dp_status_t   status_i,
  output lclp_pkg::seq_ctrl_t    ctrl_o
);
  import lclp_pkg::*;

  logic [PC_W-1:0] pc_q, pc_d;
  ucode_t          word;
  logic            hit;

  assign word = ucode_rom(pc_q);

  // Condition select
  always_comb begin
    unique case (word.cond)
      COND_ALWAYS:   hit = 1'b1;
      COND_CR:       hit = status_i.cr_seen;
      COND_END:      hit = status_i.scan_end;
      COND_OUT_FREE: hit = status_i.out_free;
      default:       hit = 1'b0;
    endcase
  end

  // Next step
  always_comb begin
    if (hit) begin
      pc_d = word.target;
    end else if (word.hold) begin
      pc_d = pc_q;
    end else begin
      pc_d = pc_q + PC_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= PC_RECV;
    end else begin
      pc_q <= pc_d;
    end
  end

  assign ctrl_o.op  = word.op;
  assign ctrl_o.hit = hit;

endmodule

@@ hdl/lclp_dp.sv @@
// Datapath: line fill, character scan, token capture, lamp state and result register.
module lclp_dp #(
  parameter int unsigned LineLen = lclp_pkg::LINE_LEN
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  lclp_pkg::seq_ctrl_t          ctrl_i,
  output lclp_pkg::dp_status_t         status_o,
  // input channel
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [7:0]                   rx_byte_i,
  // line store port
  output logic                         mem_we_o,
  output logic [$clog2(LineLen)-1:0]   mem_waddr_o,
  output logic [7:0]                   mem_wdata_o,
  output logic [$clog2(LineLen)-1:0]   mem_raddr_o,
  input  logic [7:0]                   mem_rdata_i,
  // output channel
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [1:0]                   reply_code_o,
  output logic [2:0]                   lamp_number_o,
  output logic [3:0]                   lamp_states_o
);
  import lclp_pkg::*;

  localparam int unsigned AddrW = $clog2(LineLen);
  localparam int unsigned CntW  = $clog2(LineLen + 1);

  typedef enum logic [1:0] {
    T1_SKIP,
    T1_TOK,
    T1_DONE
  } first_e;

  typedef enum logic [1:0] {
    A_WAIT,
    A_SKIP,
    A_TOK,
    A_DONE
  } arg_e;

  logic [CntW-1:0] fill_q, fill_d;
  logic [CntW-1:0] pos_q, pos_d, pos_nx;
  first_e          t1_st_q, t1_st_d;
  arg_e            a_st_q, a_st_d;
  logic [2:0]      t1_cnt_q, t1_cnt_d, a_cnt_q, a_cnt_d;
  tok_t            t1_q, t1_d, a_q, a_d;
  logic [3:0]      lamp_q, lamp_d;
  logic            out_valid_q, out_valid_d;
  logic [1:0]      code_q, code_d;
  logic [2:0]      num_q, num_d;

  logic       accept, is_cr, scan_end, fire_eval, step;
  logic [7:0] ch;
  logic       is_sp;
  logic       is_led;
  logic [1:0] lamp_idx;
  logic [3:0] lamp_bit;
  logic       arg_on, arg_off;

  assign in_ready_o = (ctrl_i.op == OP_RECV);
  assign accept     = in_valid_i && in_ready_o;
  assign is_cr      = (rx_byte_i == CH_CR);

  // Store write: non-CR bytes while room is left
  assign mem_we_o    = accept && !is_cr && (fill_q < CntW'(LineLen));
  assign mem_waddr_o = fill_q[AddrW-1:0];
  assign mem_wdata_o = rx_byte_i;

  // Read one position ahead so a character arrives every scan cycle
  assign pos_nx      = pos_q + CntW'(1);
  assign mem_raddr_o = (ctrl_i.op == OP_SCAN) ? pos_nx[AddrW-1:0] : '0;

  // Lowercase fold of the character being scanned
  always_comb begin
    ch = mem_rdata_i;
    if (mem_rdata_i >= CH_UP_A && mem_rdata_i <= CH_UP_Z) begin
      ch = mem_rdata_i + CASE_OFS;
    end
  end
  assign is_sp = (ch == CH_SPACE);

  assign scan_end  = (pos_q >= fill_q) || (mem_rdata_i == CH_NUL);
  assign step      = (ctrl_i.op == OP_SCAN) && !scan_end;
  assign fire_eval = (ctrl_i.op == OP_EVAL) && ctrl_i.hit;

  assign status_o.cr_seen  = accept && is_cr;
  assign status_o.scan_end = scan_end;
  assign status_o.out_free = !out_valid_q || out_ready_i;

  // Command decode of the captured tokens
  assign is_led   = (t1_q[2:0] == LED_PREFIX) && (t1_q[3] >= CH_ONE) && (t1_q[3] <= CH_FOUR);
  assign lamp_idx = t1_q[3][1:0] - 2'd1;
  assign lamp_bit = 4'b0001 << lamp_idx;
  assign arg_on   = (a_q == WORD_ON);
  assign arg_off  = (a_q == WORD_OFF);

  always_comb begin
    fill_d      = fill_q;
    pos_d       = pos_q;
    t1_st_d     = t1_st_q;
    a_st_d      = a_st_q;
    t1_cnt_d    = t1_cnt_q;
    a_cnt_d     = a_cnt_q;
    t1_d        = t1_q;
    a_d         = a_q;
    lamp_d      = lamp_q;
    out_valid_d = out_valid_q;
    code_d      = code_q;
    num_d       = num_q;

    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end

    if (mem_we_o) begin
      fill_d = fill_q + CntW'(1);
    end

    // Start of a scan
    if (ctrl_i.op == OP_INIT) begin
      pos_d    = '0;
      t1_st_d  = T1_SKIP;
      a_st_d   = A_WAIT;
      t1_cnt_d = '0;
      a_cnt_d  = '0;
      t1_d     = '0;
      a_d      = '0;
    end

    // One character per cycle: first token and argument token
    if (step) begin
      pos_d = pos_nx;
      unique case (t1_st_q)
        T1_SKIP, T1_TOK: begin
          if (is_sp) begin
            if (t1_st_q == T1_TOK) t1_st_d = T1_DONE;
          end else begin
            t1_st_d = T1_TOK;
            if (t1_cnt_q < 3'd4) begin
              t1_d[t1_cnt_q[1:0]] = ch;
              t1_cnt_d = t1_cnt_q + 3'd1;
            end
          end
        end
        default: ;
      endcase
      unique case (a_st_q)
        A_WAIT: begin
          if (is_sp) a_st_d = A_SKIP;
        end
        A_SKIP, A_TOK: begin
          if (is_sp) begin
            if (a_st_q == A_TOK) a_st_d = A_DONE;
          end else begin
            a_st_d = A_TOK;
            if (a_cnt_q < 3'd4) begin
              a_d[a_cnt_q[1:0]] = ch;
              a_cnt_d = a_cnt_q + 3'd1;
            end
          end
        end
        default: ;
      endcase
    end

    // Result and lamp update
    if (fire_eval) begin
      out_valid_d = 1'b1;
      fill_d      = '0;
      if (is_led) begin
        num_d = {1'b0, lamp_idx} + 3'd1;
        if (arg_on && ((lamp_q & lamp_bit) == 4'b0000)) begin
          lamp_d = lamp_q | lamp_bit;
          code_d = RPL_ON;
        end else if (arg_off && ((lamp_q & lamp_bit) != 4'b0000)) begin
          lamp_d = lamp_q & ~lamp_bit;
          code_d = RPL_OFF;
        end else begin
          code_d = RPL_ERR;
        end
      end else begin
        num_d  = 3'd0;
        code_d = RPL_HELP;
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q      <= '0;
      pos_q       <= '0;
      t1_st_q     <= T1_SKIP;
      a_st_q      <= A_WAIT;
      t1_cnt_q    <= '0;
      a_cnt_q     <= '0;
      lamp_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      fill_q      <= fill_d;
      pos_q       <= pos_d;
      t1_st_q     <= t1_st_d;
      a_st_q      <= a_st_d;
      t1_cnt_q    <= t1_cnt_d;
      a_cnt_q     <= a_cnt_d;
      lamp_q      <= lamp_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    t1_q   <= t1_d;
    a_q    <= a_d;
    code_q <= code_d;
    num_q  <= num_d;
  end

  assign out_valid_o   = out_valid_q;
  assign reply_code_o  = code_q;
  assign lamp_number_o = num_q;
  assign lamp_states_o = lamp_q;

endmodule

@@ dv/tb_led_command_line_parser.sv @@
// Testbench of the LED command line parser: directed command lines, random traffic, scoreboard.
module tb_led_command_line_parser;
  import lclp_pkg::*;

  localparam int RANDOM_ITEMS = 1200;
  localparam int CALM_AFTER   = 1250;   // requests taken before idling stops
  localparam int LONG_HOLD    = 400;    // cycles of the long receiver stall
  localparam int HOLD_AT      = 30;     // replies seen before the long stall
  localparam int SETTLE       = 2 * (LINE_LEN + 4);
  localparam int MAX_REPORTS  = 10;

  // Words the parser knows, in table order
  typedef enum int {
    TOK_ON, TOK_OFF, TOK_LED1, TOK_LED2, TOK_LED3, TOK_LED4, TOK_NONE
  } word_e;

  typedef struct packed {
    logic [1:0] code;
    logic [2:0] lamp;
    logic [3:0] lit;
  } reply_t;

  // One request as driven; CR requests may carry a typed-in reply
  typedef struct packed {
    logic [7:0] ch;
    logic       fixed;
    reply_t     want;
  } rx_item_t;

  typedef struct {
    string  head;
    int     pad;     // spaces after head
    bit     nul;     // zero byte after the padding
    string  tail;
    bit     fixed;
    reply_t want;
  } line_row_t;

  logic       clk;
  logic       rst_ni;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] rx_byte;
  logic       out_valid;
  logic       out_ready;
  logic [1:0] reply_code;
  logic [2:0] lamp_number;
  logic [3:0] lamp_states;

  rx_item_t  cur_item;
  reply_t    reply_q[$];
  line_row_t cmd_table [21];
  int        mismatches;
  int        bytes_taken;
  int        replies_seen;

  // Predictor state
  logic [7:0] line_mem [LINE_LEN];
  int         line_cnt;
  logic [3:0] lamps_lit;

  led_command_line_parser dut (
    .clk_i        (clk),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .rx_byte_i    (rx_byte),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .reply_code_o (reply_code),
    .lamp_number_o(lamp_number),
    .lamp_states_o(lamp_states)
  );

  // Clock and reset
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (7) @(negedge clk);
    rst_ni = 1'b1;
  end

  initial begin
    #6000000;
    $display("** led_command_line_parser: FAILED **");
    $finish;
  end

  function automatic logic [31:0] word_code(input word_e w);
    case (w)
      TOK_ON:   return 32'h0000_6E6F;
      TOK_OFF:  return 32'h0066_666F;
      TOK_LED1: return 32'h3164_656C;
      TOK_LED2: return 32'h3264_656C;
      TOK_LED3: return 32'h3364_656C;
      TOK_LED4: return 32'h3464_656C;
      default:  return 32'hFFFF_FFFF;
    endcase
  endfunction

  // Token at or after start, spaces skipped, first four characters kept
  function automatic word_e match_word(input logic [7:0] s [LINE_LEN], input int len,
                                       input int start);
    logic [31:0] tok;
    int p;
    int n;
    tok = '0;
    p = start;
    n = 0;
    while (p < len && s[p] == CH_SPACE) p++;
    while (p < len && s[p] != CH_SPACE) begin
      if (n < 4) tok[8*n +: 8] = s[p];
      n++;
      p++;
    end
    for (int e = TOK_ON; e <= TOK_LED4; e++) begin
      if (word_code(word_e'(e)) == tok) return word_e'(e);
    end
    return TOK_NONE;
  endfunction

  // Line store and lamp update for one request; made is set on a CR
  task automatic parse_byte(input logic [7:0] ch, output bit made, output reply_t r);
    logic [7:0] low [LINE_LEN];
    logic [7:0] c;
    int         len;
    int         lamp;
    word_e      first;
    word_e      arg;
    logic [3:0] mask;
    logic [1:0] code;
    made = 1'b0;
    r = '0;
    foreach (low[i]) low[i] = '0;
    if (ch != CH_CR) begin
      if (line_cnt < LINE_LEN) begin
        line_mem[line_cnt] = ch;
        line_cnt++;
      end
    end else begin
      // lower-case copy up to the fill count or a zero byte
      len = 0;
      while (len < line_cnt && line_mem[len] != CH_NUL) begin
        c = line_mem[len];
        if (c >= CH_UP_A && c <= CH_UP_Z) c = c + CASE_OFS;
        low[len] = c;
        len++;
      end
      first = match_word(low, len, 0);
      lamp = 0;
      if (first >= TOK_LED1 && first <= TOK_LED4) begin
        lamp = int'(first) - int'(TOK_LED1) + 1;
        mask = 4'b0001 << (lamp - 1);
        arg = TOK_NONE;
        // argument begins at the first space of the line
        for (int i = 0; i < len; i++) begin
          if (low[i] == CH_SPACE) begin
            arg = match_word(low, len, i);
            break;
          end
        end
        if (arg == TOK_ON && (lamps_lit & mask) == 4'h0) begin
          lamps_lit = lamps_lit | mask;
          code = RPL_ON;
        end else if (arg == TOK_OFF && (lamps_lit & mask) != 4'h0) begin
          lamps_lit = lamps_lit & ~mask;
          code = RPL_OFF;
        end else begin
          code = RPL_ERR;
        end
      end else begin
        code = RPL_HELP;
      end
      line_cnt = 0;
      made = 1'b1;
      r = '{code: code, lamp: lamp[2:0], lit: lamps_lit};
    end
  endtask

  // Scoreboard: check replies, then predict from the accepted request
  always @(posedge clk) begin
    bit     made;
    reply_t r;
    reply_t e;
    if (rst_ni) begin
      if (out_valid && out_ready) begin
        replies_seen++;
        if (reply_q.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("unexpected reply: code %0d lamp %0d lit %h",
                     reply_code, lamp_number, lamp_states);
        end else begin
          e = reply_q.pop_front();
          if (reply_code !== e.code || lamp_number !== e.lamp || lamp_states !== e.lit) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display("reply mismatch: expected code %0d lamp %0d lit %h, got code %0d lamp %0d lit %h",
                       e.code, e.lamp, e.lit, reply_code, lamp_number, lamp_states);
          end
        end
      end
      if (in_valid && in_ready) begin
        bytes_taken++;
        parse_byte(cur_item.ch, made, r);
        if (made) reply_q.push_back(cur_item.fixed ? cur_item.want : r);
      end
    end
  end

  // Receiver: random stalls, one long hold-off, steady at the end
  initial begin
    bit held;
    held = 1'b0;
    out_ready = 1'b0;
    wait (rst_ni);
    forever begin
      @(negedge clk);
      if (!held && replies_seen >= HOLD_AT) begin
        held = 1'b1;
        out_ready = 1'b0;
        repeat (LONG_HOLD - 1) @(negedge clk);
      end else if (bytes_taken < CALM_AFTER && $urandom_range(0, 7) == 0) begin
        out_ready = 1'b0;
        repeat ($urandom_range(1, 11) - 1) @(negedge clk);
      end else begin
        out_ready = 1'b1;
      end
    end
  end

  // Sender helpers; each starts and ends at a falling edge
  task automatic send_byte(input rx_item_t it);
    if (bytes_taken < CALM_AFTER && $urandom_range(0, 9) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
    in_valid = 1'b1;
    rx_byte  = it.ch;
    cur_item = it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic hold_until_drained();
    in_valid = 1'b0;
    while (reply_q.size() != 0) @(negedge clk);
  endtask

  task automatic push_char(ref rx_item_t q[$], input logic [7:0] c, input bit mix);
    rx_item_t it;
    it = '0;
    it.ch = c;
    if (mix && c >= 8'h61 && c <= 8'h7A && $urandom_range(0, 1) == 1) it.ch = c - CASE_OFS;
    q.push_back(it);
  endtask

  task automatic push_text(ref rx_item_t q[$], input string s);
    for (int i = 0; i < s.len(); i++) push_char(q, s[i], 1'b1);
  endtask

  task automatic push_noise(ref rx_item_t q[$], input int n);
    for (int i = 0; i < n; i++) push_char(q, 8'($urandom_range(0, 255)), 1'b0);
  endtask

  // One random command line, ended by a CR
  task automatic make_random_line(ref rx_item_t q[$]);
    int    kind;
    int    pick;
    string bad_args [5];
    bad_args = '{"of", "onn", "offf", "0n", "o f"};
    kind = $urandom_range(0, 99);
    if (kind < 75) begin
      // well-formed lamp command with random case and small defects
      if ($urandom_range(0, 9) == 0) repeat ($urandom_range(1, 2)) push_char(q, CH_SPACE, 1'b0);
      push_text(q, "led");
      pick = $urandom_range(0, 19);
      if (pick < 18) push_char(q, CH_ONE + 8'($urandom_range(0, 3)), 1'b0);
      else if (pick == 18) push_char(q, 8'h30, 1'b0);
      else push_char(q, CH_FOUR + 8'd1, 1'b0);
      if ($urandom_range(0, 9) == 0) push_char(q, 8'h61 + 8'($urandom_range(0, 25)), 1'b1);
      if ($urandom_range(0, 19) != 0) begin
        if ($urandom_range(0, 7) == 0) repeat ($urandom_range(2, 3)) push_char(q, CH_SPACE, 1'b0);
        else push_char(q, CH_SPACE, 1'b0);
        pick = $urandom_range(0, 19);
        if (pick < 9) push_text(q, "on");
        else if (pick < 18) push_text(q, "off");
        else push_text(q, bad_args[$urandom_range(0, 4)]);
        if ($urandom_range(0, 9) == 0) begin
          push_char(q, CH_SPACE, 1'b0);
          push_noise(q, $urandom_range(1, 4));
        end
      end
      if (kind >= 70) begin
        // long line: padding that can run past the end of the store
        if ($urandom_range(0, 1) == 1) repeat ($urandom_range(20, 40)) push_char(q, CH_SPACE, 1'b0);
        else push_noise(q, $urandom_range(20, 40));
      end
    end else if (kind < 87) begin
      push_text(q, "led");
      push_noise(q, $urandom_range(0, 10));
    end else begin
      push_noise(q, $urandom_range(0, 12));
    end
    push_char(q, CH_CR, 1'b0);
  endtask

  // Sender: directed table, random lines, then the final check
  initial begin
    rx_item_t line_q[$];
    rx_item_t it;
    int       sent;
    int       lines;
    in_valid     = 1'b0;
    rx_byte      = '0;
    cur_item     = '0;
    mismatches   = 0;
    bytes_taken  = 0;
    replies_seen = 0;
    line_cnt     = 0;
    lamps_lit    = '0;
    foreach (line_mem[i]) line_mem[i] = '0;

    cmd_table = '{
      '{"",            0, 1'b0, "",        1'b1, '{RPL_HELP, 3'd0, 4'b0000}},
      '{"led1 on",     0, 1'b0, "",        1'b1, '{RPL_ON,   3'd1, 4'b0001}},
      '{"LED1 ON",     0, 1'b0, "",        1'b1, '{RPL_ERR,  3'd1, 4'b0001}},
      '{"led1 off",    0, 1'b0, "",        1'b1, '{RPL_OFF,  3'd1, 4'b0000}},
      '{"led1",        0, 1'b0, "",        1'b1, '{RPL_ERR,  3'd1, 4'b0000}},
      '{"  led2 on",   0, 1'b0, "",        1'b1, '{RPL_ERR,  3'd2, 4'b0000}},
      '{"led2x on",    0, 1'b0, "",        1'b1, '{RPL_ON,   3'd2, 4'b0010}},
      '{"led3 maybe",  0, 1'b0, "",        1'b1, '{RPL_ERR,  3'd3, 4'b0010}},
      '{"led4 On",     0, 1'b0, "",        1'b1, '{RPL_ON,   3'd4, 4'b1010}},
      '{"lamp on",     0, 1'b0, "",        1'b1, '{RPL_HELP, 3'd0, 4'b1010}},
      '{"led3 on",    30, 1'b0, "zz",      1'b0, '0},
      '{"led4 of",     0, 1'b1, "f",       1'b1, '{RPL_ERR,  3'd4, 4'b1110}},
      '{"led5 on",     0, 1'b0, "",        1'b1, '{RPL_HELP, 3'd0, 4'b1110}},
      '{"\377\200",    0, 1'b0, "",        1'b1, '{RPL_HELP, 3'd0, 4'b1110}},
      '{"led2 off",    0, 1'b0, "",        1'b1, '{RPL_OFF,  3'd2, 4'b1100}},
      '{"Led4 oFF",    0, 1'b0, "",        1'b1, '{RPL_OFF,  3'd4, 4'b0100}},
      '{"led3 offx",   0, 1'b0, "",        1'b1, '{RPL_ERR,  3'd3, 4'b0100}},
      '{"led1  on",    0, 1'b0, "",        1'b0, '0},
      '{"on",          0, 1'b0, "",        1'b1, '{RPL_HELP, 3'd0, 4'b0101}},
      '{"led3 OFF",    0, 1'b0, "",        1'b1, '{RPL_OFF,  3'd3, 4'b0001}},
      '{"",            0, 1'b1, "led1 on", 1'b1, '{RPL_HELP, 3'd0, 4'b0001}}
    };

    wait (rst_ni);
    @(negedge clk);

    // directed lines: head, padding, optional zero byte, tail, CR
    foreach (cmd_table[r]) begin
      line_q.delete();
      for (int i = 0; i < cmd_table[r].head.len(); i++) push_char(line_q, cmd_table[r].head[i], 1'b0);
      repeat (cmd_table[r].pad) push_char(line_q, CH_SPACE, 1'b0);
      if (cmd_table[r].nul) push_char(line_q, CH_NUL, 1'b0);
      for (int i = 0; i < cmd_table[r].tail.len(); i++) push_char(line_q, cmd_table[r].tail[i], 1'b0);
      it = '0;
      it.ch    = CH_CR;
      it.fixed = cmd_table[r].fixed;
      it.want  = cmd_table[r].want;
      line_q.push_back(it);
      foreach (line_q[k]) send_byte(line_q[k]);
    end
    hold_until_drained();

    // random lines; one pause for a full drain along the way
    sent  = 0;
    lines = 0;
    while (sent < RANDOM_ITEMS) begin
      line_q.delete();
      make_random_line(line_q);
      foreach (line_q[k]) send_byte(line_q[k]);
      sent += line_q.size();
      lines++;
      if (lines == 80) hold_until_drained();
    end

    hold_until_drained();
    repeat (SETTLE) @(negedge clk);
    while (reply_q.size() != 0) begin
      it.want = reply_q.pop_front();
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("missing reply: expected code %0d lamp %0d lit %h",
                 it.want.code, it.want.lamp, it.want.lit);
    end
    if (mismatches == 0) begin
      $display("** led_command_line_parser: PASSED **");
    end else begin
      $display("** led_command_line_parser: FAILED **");
    end
    $finish;
  end

endmodule
